// File: rtl/assert_macros.svh
// Assertion helpers included by the vertex welder unit.
// Each check is clocked on clk and switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds on every rising clock edge.
`define VWI_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define VWI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define VWI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/vwi_pkg.sv
package vwi_pkg;

    // Field widths
    localparam int COORD_W   = 21;
    localparam int TOL_W     = 20;
    localparam int OUT_IDX_W = 8;

    // Distance arithmetic widths: difference, square, sum of squares
    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int SQ_W   = 2 * DIFF_W - 1;
    localparam int SUM_W  = SQ_W + 1;

    // Merge tolerance after reset: 0.1 px squared, rounded up
    localparam logic [TOL_W-1:0] TOL_RESET = 20'd41;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic [TOL_W-1:0]          tol_t;

    // One stored vertex: x in the low half, y in the high half
    typedef struct packed {
        coord_t y;
        coord_t x;
    } vert_t;

endpackage

// File: rtl/vwi_cell.sv
module vwi_cell (
    input  logic          clk,
    input  logic          shift_en,
    input  vwi_pkg::vert_t vert_in,
    output vwi_pkg::vert_t vert_out
);
    import vwi_pkg::*;

    vert_t vert_reg;

    // Take the neighbour's vertex on every shift
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            vert_reg <= vert_in;
        end
    end

    assign vert_out = vert_reg;

endmodule

// File: rtl/vwi_dist.sv
module vwi_dist #(
    parameter int TAG_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              probe_valid,
    input  logic [TAG_W-1:0]  probe_tag,
    input  vwi_pkg::vert_t    entry,
    input  vwi_pkg::vert_t    point,
    input  vwi_pkg::tol_t     tol,
    output logic              hit,
    output logic [TAG_W-1:0]  hit_tag
);
    import vwi_pkg::*;

    logic              s1_valid_reg;
    logic [TAG_W-1:0]  s1_tag_reg;
    diff_t             dx_reg;
    diff_t             dy_reg;
    logic              s2_valid_reg;
    logic [TAG_W-1:0]  s2_tag_reg;
    logic [SQ_W-1:0]   sqx_reg;
    logic [SQ_W-1:0]   sqy_reg;

    diff_t             dx_next;
    diff_t             dy_next;
    logic signed [PROD_W-1:0] sqx_full;
    logic signed [PROD_W-1:0] sqy_full;
    logic [SUM_W-1:0]  dist_sum;

    // Stage 1: coordinate differences
    assign dx_next = DIFF_W'(entry.x) - DIFF_W'(point.x);
    assign dy_next = DIFF_W'(entry.y) - DIFF_W'(point.y);

    // Stage 2: squares
    assign sqx_full = dx_reg * dx_reg;
    assign sqy_full = dy_reg * dy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= probe_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_tag_reg <= probe_tag;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        s2_tag_reg <= s1_tag_reg;
        sqx_reg    <= sqx_full[SQ_W-1:0];
        sqy_reg    <= sqy_full[SQ_W-1:0];
    end

    // Stage 3: add squares and compare with the tolerance
    assign dist_sum = SUM_W'(sqx_reg) + SUM_W'(sqy_reg);
    assign hit      = s2_valid_reg && (dist_sum < SUM_W'(tol));
    assign hit_tag  = s2_tag_reg;

endmodule

// File: rtl/vertex_weld_indexer_unit.sv
// Vertex welder: maps a stream of 2D triangle corners onto indices of a
// table of unique vertices, merging points closer than a set tolerance.
// Input channel (in_valid/in_ready): one corner per beat, point_x and
// point_y in signed 1/64 pixel units; start_mesh clears the vertex table
// and the corner count before the point is looked up.
// Output channel (out_valid/out_ready): one result beat per corner with
// the vertex index, new/overflow flags and, on every third corner, whether
// the triangle's three indices are distinct.
// Config channel (cfg_valid/cfg_ready): writes the squared merge tolerance;
// always ready, write it only while the block is idle.
// The table sits in a ring of MAX_VERTS cells that makes one full
// revolution past a single pipelined distance unit per corner; the corner
// then passes the DRAIN and DONE states, and its result is loaded into the
// output register before the next corner is accepted.
// A finished result waits in the output register; if the receiver stalls,
// the following corner is still taken and scanned, then held until the
// output register frees. Reset empties the table and sets the tolerance
// to 41.
module vertex_weld_indexer_unit #(
    parameter int MAX_VERTS = 256
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  vwi_pkg::tol_t                          cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  vwi_pkg::coord_t                        point_x,
    input  vwi_pkg::coord_t                        point_y,
    input  logic                                   start_mesh,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [vwi_pkg::OUT_IDX_W-1:0]          vertex_index,
    output logic                                   is_new,
    output logic                                   table_overflow,
    output logic                                   triangle_done,
    output logic                                   triangle_valid
);
    import vwi_pkg::*;
    `include "assert_macros.svh"

    localparam int IDX_W = $clog2(MAX_VERTS);
    localparam int CNT_W = $clog2(MAX_VERTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTS);
    localparam logic [IDX_W-1:0] STEP_LAST = IDX_W'(MAX_VERTS - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    localparam logic [1:0] CORNER_FIRST  = 2'd0;
    localparam logic [1:0] CORNER_SECOND = 2'd1;
    localparam logic [1:0] CORNER_THIRD  = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [IDX_W-1:0] step_reg;
    logic             drain_reg;
    logic [CNT_W-1:0] count_reg;
    logic [1:0]       corner_reg;
    logic [IDX_W-1:0] first_reg;
    logic [IDX_W-1:0] second_reg;
    logic             found_reg;
    logic [IDX_W-1:0] match_reg;
    tol_t             tol_reg;
    vert_t            point_reg;

    logic [OUT_IDX_W-1:0] idx_out_reg;
    logic             new_out_reg;
    logic             ovf_out_reg;
    logic             done_out_reg;
    logic             tri_out_reg;
    logic             out_valid_reg;

    vert_t            ring_q [MAX_VERTS];
    vert_t            tail_in;
    logic             shift_en;
    logic [CNT_W-1:0] step_ext;
    logic             probe_valid;
    logic             hit;
    logic [IDX_W-1:0] hit_tag;

    logic             finish;
    logic             res_new;
    logic             res_ovf;
    logic [IDX_W-1:0] res_idx;
    logic [IDX_W+OUT_IDX_W-1:0] res_idx_wide;
    logic             res_done;
    logic             res_tri;

    // Vertex ring: each cell hands its vertex to the one below per shift
    assign shift_en = (state_reg == ST_SCAN);
    assign step_ext = CNT_W'(step_reg);
    // Drop the point into the first free slot as it passes the head
    assign tail_in  = (step_ext == count_reg) ? point_reg : ring_q[0];

    genvar gi;
    generate
        for (gi = 0; gi < MAX_VERTS; gi++)
        begin : g_ring
            if (gi == MAX_VERTS - 1)
            begin : g_tail
                vwi_cell u_cell (
                    .clk      (clk),
                    .shift_en (shift_en),
                    .vert_in  (tail_in),
                    .vert_out (ring_q[gi])
                );
            end
            else
            begin : g_body
                vwi_cell u_cell (
                    .clk      (clk),
                    .shift_en (shift_en),
                    .vert_in  (ring_q[gi+1]),
                    .vert_out (ring_q[gi])
                );
            end
        end
    endgenerate

    // Compare the head entry against the point while it is a live vertex
    assign probe_valid = shift_en && (step_ext < count_reg);

    vwi_dist #(
        .TAG_W (IDX_W)
    ) u_dist (
        .clk         (clk),
        .rst_n       (rst_n),
        .probe_valid (probe_valid),
        .probe_tag   (step_reg),
        .entry       (ring_q[0]),
        .point       (point_reg),
        .tol         (tol_reg),
        .hit         (hit),
        .hit_tag     (hit_tag)
    );

    // Handshakes
    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign finish    = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drain_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Resolve the lookup: match, append or overflow
    always_comb
    begin
        res_new = 1'b0;
        res_ovf = 1'b0;
        res_idx = match_reg;
        if (!found_reg)
        begin
            if (count_reg < CNT_MAX)
            begin
                res_idx = count_reg[IDX_W-1:0];
                res_new = 1'b1;
            end
            else
            begin
                res_idx = '0;
                res_ovf = 1'b1;
            end
        end
    end

    assign res_idx_wide = {{OUT_IDX_W{1'b0}}, res_idx};
    assign res_done     = (corner_reg != CORNER_FIRST) && (corner_reg != CORNER_SECOND);
    assign res_tri      = res_done && (first_reg != second_reg)
                          && (second_reg != res_idx) && (first_reg != res_idx);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            drain_reg     <= 1'b0;
            count_reg     <= '0;
            corner_reg    <= CORNER_FIRST;
            first_reg     <= '0;
            second_reg    <= '0;
            found_reg     <= 1'b0;
            tol_reg       <= TOL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                tol_reg <= cfg_data;
            end

            // Start a scan; a start flag empties the mesh first
            if (in_valid && in_ready)
            begin
                step_reg  <= '0;
                found_reg <= 1'b0;
                if (start_mesh)
                begin
                    count_reg  <= '0;
                    corner_reg <= CORNER_FIRST;
                end
            end

            // Advance the ring position
            if (state_reg == ST_SCAN)
            begin
                step_reg  <= step_reg + 1'b1;
                drain_reg <= 1'b0;
            end

            if (state_reg == ST_DRAIN)
            begin
                drain_reg <= 1'b1;
            end

            // Hold only the first hit in stored order
            if (hit && !found_reg)
            begin
                found_reg <= 1'b1;
            end

            // Load a finished result, or drop the beat the receiver took
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // Commit the result and advance the triangle corner
            if (finish)
            begin
                if (res_new)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                case (corner_reg)
                    CORNER_FIRST:
                    begin
                        first_reg  <= res_idx;
                        corner_reg <= CORNER_SECOND;
                    end
                    CORNER_SECOND:
                    begin
                        second_reg <= res_idx;
                        corner_reg <= CORNER_THIRD;
                    end
                    default:
                    begin
                        corner_reg <= CORNER_FIRST;
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            point_reg.x <= point_x;
            point_reg.y <= point_y;
        end
        if (hit && !found_reg)
        begin
            match_reg <= hit_tag;
        end
        if (finish)
        begin
            idx_out_reg  <= res_idx_wide[OUT_IDX_W-1:0];
            new_out_reg  <= res_new;
            ovf_out_reg  <= res_ovf;
            done_out_reg <= res_done;
            tri_out_reg  <= res_tri;
        end
    end

    assign out_valid      = out_valid_reg;
    assign vertex_index   = idx_out_reg;
    assign is_new         = new_out_reg;
    assign table_overflow = ovf_out_reg;
    assign triangle_done  = done_out_reg;
    assign triangle_valid = tri_out_reg;

    `VWI_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_MAX, "vertex count beyond table size")
    `VWI_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second corner taken mid scan")
    `VWI_ASSERT_SAME(a_new_xor_ovf, finish, !(res_new && res_ovf), "append and overflow together")
    `VWI_ASSERT_SAME(a_hit_in_scan, hit, (state_reg == ST_SCAN) || (state_reg == ST_DRAIN),
                     "distance hit outside a scan")

endmodule

// File: dv/vertex_weld_indexer_unit_tb.sv
module vertex_weld_indexer_unit_tb;

    import vwi_pkg::*;

    localparam int WELD_DEPTH = 256;
    localparam int HOLDOFF_CYCLES = 1500;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct {
        coord_t x;
        coord_t y;
        logic   start;
    } corner_t;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] index;
        logic                 fresh;
        logic                 overflow;
        logic                 done;
        logic                 valid;
    } weld_result_t;

    // Clock, reset and block inputs, all known from time zero
    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   cfg_valid = 1'b0;
    logic   cfg_ready;
    tol_t   cfg_data = '0;
    logic   in_valid = 1'b0;
    logic   in_ready;
    coord_t point_x = '0;
    coord_t point_y = '0;
    logic   start_mesh = 1'b0;
    logic   out_valid;
    logic   out_ready = 1'b0;
    logic [OUT_IDX_W-1:0] vertex_index;
    logic   is_new;
    logic   table_overflow;
    logic   triangle_done;
    logic   triangle_valid;

    // Predicted state of the welder
    vert_t  weld_table [WELD_DEPTH];
    int     weld_count = 0;
    int     weld_corners = 0;
    int     weld_first = 0;
    int     weld_second = 0;
    tol_t   weld_tol = TOL_RESET;

    corner_t      pending_corners [$];
    weld_result_t expected_welds [$];
    int           corners_queued = 0;
    int           welds_seen = 0;
    int           fail_count = 0;
    idle_mode_t   idle_mode = IDLE_NONE;
    int           holdoff_left = 0;
    logic         corner_beat = 1'b0;
    logic         tol_beat = 1'b0;
    logic         sender_rest;
    corner_t      next_corner;

    vertex_weld_indexer_unit #(
        .MAX_VERTS(WELD_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .point_x(point_x),
        .point_y(point_y),
        .start_mesh(start_mesh),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .vertex_index(vertex_index),
        .is_new(is_new),
        .table_overflow(table_overflow),
        .triangle_done(triangle_done),
        .triangle_valid(triangle_valid)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Weld one corner into the predicted table and work out its result beat
    function automatic weld_result_t weld_corner(corner_t c);
        weld_result_t r;
        int     hit;
        longint dx;
        longint dy;
        r = '0;
        hit = -1;
        if (c.start)
        begin
            weld_count = 0;
            weld_corners = 0;
        end
        // first stored entry strictly inside the tolerance wins
        for (int i = 0; i < weld_count; i++)
        begin
            dx = longint'(weld_table[i].x) - longint'(c.x);
            dy = longint'(weld_table[i].y) - longint'(c.y);
            if (hit < 0 && dx * dx + dy * dy < longint'(weld_tol))
                hit = i;
        end
        if (hit < 0)
        begin
            if (weld_count < WELD_DEPTH)
            begin
                hit = weld_count;
                weld_table[hit].x = c.x;
                weld_table[hit].y = c.y;
                weld_count++;
                r.fresh = 1'b1;
            end
            else
            begin
                hit = 0;
                r.overflow = 1'b1;
            end
        end
        // track the corners of the open triangle
        case (weld_corners)
            0:
            begin
                weld_first = hit;
                weld_corners = 1;
            end
            1:
            begin
                weld_second = hit;
                weld_corners = 2;
            end
            default:
            begin
                r.done = 1'b1;
                r.valid = weld_first != weld_second && weld_second != hit
                          && weld_first != hit;
                weld_corners = 0;
            end
        endcase
        r.index = hit[OUT_IDX_W-1:0];
        return r;
    endfunction

    task automatic note_mismatch(string what, int got, int want);
        fail_count++;
        $display("mismatch on %s at result %0d: got %0d, want %0d",
                 what, welds_seen, got, want);
    endtask

    // Sample handshakes, predict accepted corners and check result beats
    always @(posedge clk)
    begin
        weld_result_t want;
        corner_beat <= in_valid && in_ready;
        tol_beat <= cfg_valid && cfg_ready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                weld_tol = cfg_data;
            if (out_valid && out_ready)
            begin
                if (expected_welds.size() == 0)
                    note_mismatch("unexpected beat", vertex_index, 0);
                else
                begin
                    want = expected_welds.pop_front();
                    if (vertex_index !== want.index)
                        note_mismatch("vertex_index", vertex_index, want.index);
                    if (is_new !== want.fresh)
                        note_mismatch("is_new", is_new, want.fresh);
                    if (table_overflow !== want.overflow)
                        note_mismatch("table_overflow", table_overflow, want.overflow);
                    if (triangle_done !== want.done)
                        note_mismatch("triangle_done", triangle_done, want.done);
                    if (triangle_valid !== want.valid)
                        note_mismatch("triangle_valid", triangle_valid, want.valid);
                end
                welds_seen++;
            end
            if (in_valid && in_ready)
                expected_welds.push_back(weld_corner('{point_x, point_y, start_mesh}));
        end
    end

    // Count down a long receiver hold-off
    always @(posedge clk)
    begin
        if (holdoff_left > 0)
            holdoff_left <= holdoff_left - 1;
    end

    // Drive corners from the pending queue; hold each beat until taken
    always @(negedge clk)
    begin
        if (!in_valid || corner_beat)
        begin
            sender_rest = (idle_mode == IDLE_SENDER && $urandom_range(0, 99) < 62)
                       || (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 31);
            if (rst_n && pending_corners.size() != 0 && !sender_rest)
            begin
                next_corner = pending_corners.pop_front();
                in_valid <= 1'b1;
                point_x <= next_corner.x;
                point_y <= next_corner.y;
                start_mesh <= next_corner.start;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver readiness
    always @(negedge clk)
    begin
        if (!rst_n || holdoff_left > 0)
            out_ready <= 1'b0;
        else if (idle_mode == IDLE_RECEIVER)
            out_ready <= $urandom_range(0, 99) >= 62;
        else if (idle_mode == IDLE_BOTH)
            out_ready <= $urandom_range(0, 99) >= 31;
        else
            out_ready <= 1'b1;
    end

    task automatic queue_corner(int x, int y, bit start);
        corner_t c;
        c.x = coord_t'(x);
        c.y = coord_t'(y);
        c.start = start;
        pending_corners.push_back(c);
        corners_queued++;
    endtask

    // Write the merge tolerance; only called with the block idle
    task automatic write_tolerance(tol_t value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(negedge clk);
        while (!tol_beat);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_welds_settled();
        do
            @(negedge clk);
        while (welds_seen < corners_queued);
        repeat (8) @(negedge clk);
    endtask

    // Meshes of random corners, close to half near earlier ones so that they weld
    task automatic queue_random_meshes(int n);
        int recent_x [$];
        int recent_y [$];
        int spread [7] = '{0, 3, 6, 7, 30, 1023, 1100};
        int x;
        int y;
        int s;
        int pick;
        int roll;
        bit start;
        for (int k = 0; k < n; k++)
        begin
            start = $urandom_range(0, 99) < 6;
            if (start)
            begin
                recent_x.delete();
                recent_y.delete();
            end
            roll = $urandom_range(0, 99);
            if (roll < 45 && recent_x.size() != 0)
            begin
                pick = $urandom_range(0, recent_x.size() - 1);
                s = spread[$urandom_range(0, 6)];
                x = recent_x[pick] + int'($urandom_range(0, 2 * s)) - s;
                y = recent_y[pick] + int'($urandom_range(0, 2 * s)) - s;
                // stay inside the coordinate range
                x = x > 1048575 ? 1048575 : (x < -1048576 ? -1048576 : x);
                y = y > 1048575 ? 1048575 : (y < -1048576 ? -1048576 : y);
            end
            else if (roll < 85)
            begin
                x = int'($urandom_range(0, 255)) - 128;
                y = int'($urandom_range(0, 255)) - 128;
            end
            else
            begin
                x = int'($urandom_range(0, 2097151)) - 1048576;
                y = int'($urandom_range(0, 2097151)) - 1048576;
            end
            queue_corner(x, y, start);
            recent_x.push_back(x);
            recent_y.push_back(y);
            if (recent_x.size() > 32)
            begin
                void'(recent_x.pop_front());
                void'(recent_y.pop_front());
            end
        end
    endtask

    // Fill one mesh well past the table size, mixing in welds of stored points
    task automatic queue_overflow_mesh();
        int stored_x [$];
        int stored_y [$];
        int pick;
        int k;
        int y;
        k = 0;
        for (int i = 0; i < 330; i++)
        begin
            if (i % 7 == 6)
            begin
                pick = $urandom_range(0, stored_x.size() - 1);
                queue_corner(stored_x[pick], stored_y[pick], 1'b0);
            end
            else
            begin
                y = int'($urandom_range(0, 1000)) - 500;
                queue_corner(-1000000 + k * 7000, y, i == 0);
                stored_x.push_back(-1000000 + k * 7000);
                stored_y.push_back(y);
                k++;
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed corners at the reset tolerance, no idling
        idle_mode = IDLE_NONE;
        queue_corner(0, 0, 1'b1);
        queue_corner(6, 2, 1'b0);                 // just inside the tolerance
        queue_corner(6, -2, 1'b0);                // all three corners welded
        queue_corner(-1048576, -1048576, 1'b1);
        queue_corner(1048575, 1048575, 1'b0);
        queue_corner(1048575, -1048576, 1'b0);
        queue_corner(-1048576, 1048575, 1'b0);
        queue_corner(0, 0, 1'b0);
        queue_corner(5, 4, 1'b0);                 // exactly on the tolerance
        queue_corner(6, 2, 1'b0);                 // two candidates, earlier wins
        queue_corner(1048574, 1048575, 1'b0);
        queue_corner(-1048576, -1048576, 1'b0);
        queue_corner(100, 100, 1'b1);
        queue_corner(100, 100, 1'b0);
        queue_corner(300, 300, 1'b0);
        queue_corner(300, 300, 1'b0);
        queue_corner(100, 100, 1'b0);
        queue_corner(300, 300, 1'b0);             // first and third corners equal
        queue_corner(500, 0, 1'b0);
        queue_corner(0, 500, 1'b0);
        queue_corner(300, 301, 1'b0);
        queue_corner(7, 7, 1'b0);
        queue_corner(1, 1, 1'b1);                 // restart mesh mid-triangle
        queue_corner(2, 2, 1'b0);
        wait_welds_settled();

        // Zero tolerance: nothing ever welds
        write_tolerance('0);
        idle_mode = IDLE_SENDER;
        queue_random_meshes(140);
        wait_welds_settled();

        // Widest tolerance with a stalling receiver and one long hold-off
        write_tolerance('1);
        idle_mode = IDLE_RECEIVER;
        queue_random_meshes(140);
        repeat (400) @(negedge clk);
        holdoff_left = HOLDOFF_CYCLES;
        wait_welds_settled();

        // Table overflow at the reset tolerance
        write_tolerance(TOL_RESET);
        idle_mode = IDLE_NONE;
        queue_overflow_mesh();
        wait_welds_settled();

        write_tolerance(tol_t'($urandom_range(0, 5000)));
        idle_mode = IDLE_BOTH;
        queue_random_meshes(180);
        wait_welds_settled();

        write_tolerance(tol_t'($urandom_range(0, 1048575)));
        idle_mode = IDLE_NONE;
        queue_random_meshes(40);
        wait_welds_settled();

        repeat (WELD_DEPTH + 40) @(negedge clk);
        if (expected_welds.size() != 0)
            note_mismatch("leftover expectations", expected_welds.size(), 0);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Give up on a hung run
    initial
    begin
        #30_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
